### hdl/assert_macros.svh
// Assertion macros used by the checker file of the echo block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, including while reset is held.
`define MTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked on every rising edge outside reset.
`define MTE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

### hdl/mte_pkg.sv
// Package with the constants, register indexes and types of the multi-tap echo block.
`default_nettype none
package mte_pkg;

  localparam int HIST_DEPTH = 65536;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int SEEN_W     = HIST_AW + 1;
  localparam int DIST_W     = SEEN_W + 1;
  localparam int MAX_TAPS   = 10;
  localparam int TAP_W      = $clog2(MAX_TAPS + 2);

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int FRAC_W     = 16;
  localparam int DELAY_W    = 16;
  localparam int CFG_TAP_W  = 4;
  localparam int PROD_W     = GAIN_W + 1 + SAMPLE_W;
  localparam int ACC_W      = SAMPLE_W + FRAC_W + $clog2(MAX_TAPS + 1) + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd2;

  localparam logic [DELAY_W-1:0]   DELAY_RST = 16'd4410;
  localparam logic [CFG_TAP_W-1:0] TAPS_RST  = 4'd1;
  localparam logic [GAIN_W-1:0]    DECAY_RST = 16'd32768;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MAC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic accum;
    logic read;
    logic mac;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic tap_ok;
  } dp_status_t;

endpackage
`default_nettype wire

### hdl/mte_if.sv
// Channel interfaces: input samples, results and configuration writes.
`default_nettype none
interface mte_sample_if import mte_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface mte_result_if import mte_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

interface mte_cfg_if import mte_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hdl/mte_ctrl.sv
// Sequencer of the echo block: walks the taps of one sample and hands off the result.
`default_nettype none
module mte_ctrl import mte_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // The product of the previous tap lands in the accumulator here.
        cmd.accum = 1'b1;
        if (status.tap_ok) begin
          cmd.read   = 1'b1;
          state_next = ST_MAC;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_MAC: begin
        cmd.mac    = 1'b1;
        state_next = ST_CHECK;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule
`default_nettype wire

### hdl/mte_datapath.sv
// Datapath of the echo block: registers, sample history, tap multiply-accumulate and rounding.
`default_nettype none
module mte_datapath import mte_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire dp_cmd_t                    cmd,
  output dp_status_t                      status,
  input  wire logic                       cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  output logic signed [SAMPLE_W-1:0]      sample_out,
  output logic                            clipped
);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [ACC_W-1:0] OUT_MAX    = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] OUT_MIN    = -(ACC_W'(1) <<< (SAMPLE_W - 1));

  logic [DELAY_W-1:0]   delay_samples;
  logic [CFG_TAP_W-1:0] tap_count;
  logic [GAIN_W-1:0]    decay;

  logic signed [SAMPLE_W-1:0] x;
  logic signed [ACC_W-1:0]    acc;
  logic signed [PROD_W-1:0]   prod;
  logic [GAIN_W-1:0]          gain;
  logic [DIST_W-1:0]          tap_dist;
  logic [TAP_W-1:0]           tap_num;
  logic [TAP_W-1:0]           taps_eff;
  logic [HIST_AW-1:0]         write_index;
  logic [SEEN_W-1:0]          samples_seen;
  logic signed [SAMPLE_W-1:0] rdata;

  logic signed [SAMPLE_W-1:0] history [HIST_DEPTH];

  logic [HIST_AW-1:0]         raddr;
  logic [TAP_W-1:0]           taps_clamped;
  logic [2*GAIN_W:0]          gain_prod;
  logic signed [ACC_W-1:0]    rounded;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= DELAY_RST;
      tap_count     <= TAPS_RST;
      decay         <= DECAY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DELAY: delay_samples <= cfg_data[DELAY_W-1:0];
        REG_TAPS:  tap_count     <= cfg_data[CFG_TAP_W-1:0];
        REG_DECAY: decay         <= cfg_data[GAIN_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    if (tap_count == '0) begin
      taps_clamped = TAP_W'(1);
    end else if (TAP_W'(tap_count) > TAP_W'(MAX_TAPS)) begin
      taps_clamped = TAP_W'(MAX_TAPS);
    end else begin
      taps_clamped = TAP_W'(tap_count);
    end
  end

  // A tap is used only while its distance stays within the samples already stored.
  assign status.tap_ok = (delay_samples != '0) && (tap_num <= taps_eff) &&
                         (tap_dist <= DIST_W'(samples_seen));

  assign raddr     = write_index - tap_dist[HIST_AW-1:0];
  assign gain_prod = (2*GAIN_W+1)'(gain) * (2*GAIN_W+1)'(decay) + (2*GAIN_W+1)'(ROUND_HALF);
  assign rounded   = (acc + ROUND_HALF) >>> FRAC_W;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x        <= sample_in;
      acc      <= ACC_W'(sample_in) <<< FRAC_W;
      prod     <= '0;
      gain     <= decay;
      tap_dist <= DIST_W'(delay_samples);
      tap_num  <= TAP_W'(1);
      taps_eff <= taps_clamped;
    end
    if (cmd.accum) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.mac) begin
      prod     <= PROD_W'($signed({1'b0, gain}) * rdata);
      gain     <= gain_prod[FRAC_W +: GAIN_W];
      tap_dist <= tap_dist + DIST_W'(delay_samples);
      tap_num  <= tap_num + TAP_W'(1);
    end
    if (cmd.commit) begin
      if (rounded > OUT_MAX) begin
        sample_out <= OUT_MAX[SAMPLE_W-1:0];
        clipped    <= 1'b1;
      end else if (rounded < OUT_MIN) begin
        sample_out <= OUT_MIN[SAMPLE_W-1:0];
        clipped    <= 1'b1;
      end else begin
        sample_out <= rounded[SAMPLE_W-1:0];
        clipped    <= 1'b0;
      end
    end
  end

  // History memory: one write per sample, one registered read per tap.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      history[write_index] <= x;
    end
    if (cmd.read) begin
      rdata <= history[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index  <= '0;
      samples_seen <= '0;
    end else if (cmd.commit) begin
      write_index <= write_index + HIST_AW'(1);
      if (samples_seen < SEEN_W'(HIST_DEPTH)) begin
        samples_seen <= samples_seen + SEEN_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

### hdl/multi_tap_echo_reverb_top.sv
// Top level of the multi-tap feedforward echo block.
// Each accepted sample yields one result: the sample plus decay^r times the
// sample taken r*delay_samples beats earlier, for up to tap_count taps (0 is
// taken as 1, at most 10), rounded once and saturated to 16 bits with a clip
// flag. One sample is in work at a time. Its result is loaded into the output
// register once the T taps actually used (0 to 10) have been run and the
// output register is free, and the next sample can be accepted after that.
// Each tap needs one registered read of the history memory followed by one
// multiply. A finished result waits in an output register, so the next sample
// is taken while it is unclaimed; that sample's result is held back until the
// waiting one has been taken.
// No clearing pass is needed after reset; taps that reach past the samples
// stored so far are skipped.
`default_nettype none
module multi_tap_echo_reverb_top import mte_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  mte_sample_if.sink    samples,
  mte_result_if.source  results,
  mte_cfg_if.sink       cfg
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  mte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mte_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .sample_in  (samples.sample_in),
    .sample_out (results.sample_out),
    .clipped    (results.clipped)
  );

endmodule
`default_nettype wire

### hdl/mte_checker.sv
// Port-level checker for the echo block and its bind to the top level.
`include "assert_macros.svh"
`default_nettype none
module mte_checker import mte_pkg::*; (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic signed [SAMPLE_W-1:0] sample_out,
  input wire logic                       clipped
);

  logic [1:0] pending;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // Samples accepted whose result has not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_beat) - 2'(out_beat);
    end
  end

  `MTE_ASSERT_ALWAYS(a_no_result_after_reset, clk, rst |=> !out_valid, "result after reset")
  `MTE_ASSERT(a_pending_bound, clk, rst, pending != 2'd3, "more than two samples outstanding")
  `MTE_ASSERT(a_result_has_sample, clk, rst, out_valid |-> pending != 2'd0, "result without a sample")
  `MTE_ASSERT(a_clip_at_rail, clk, rst, (out_valid && clipped) |-> (sample_out == 16'sh7fff || sample_out == -16'sh8000), "clip flag off the rails")
  `MTE_ASSERT(a_result_holds, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(sample_out) && $stable(clipped)), "stalled result changed")

endmodule

bind multi_tap_echo_reverb_top mte_checker u_mte_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .sample_out (results.sample_out),
  .clipped    (results.clipped)
);
`default_nettype wire
